// ----- rtl/core/ptrm_pkg.sv -----
// Package for the point table radius match unit.
// Holds the request and response transfer types, operation codes and field widths.
// Depends on nothing.
package ptrm_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int KIND_W  = 3;
   localparam int COORD_W = 16;
   localparam int RAD_W   = 31;
   localparam int SLOT_W  = 6;
   localparam int FILL_W  = 7;
   localparam int SQ_W    = 2 * COORD_W;

   localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIND     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIND_ADD = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] x_coord;
      logic [COORD_W-1:0] y_coord;
      logic [RAD_W-1:0]   radius_sq;
   } req_type;

   typedef struct packed {
      logic               found;
      logic               added;
      logic               overflow;
      logic [SLOT_W-1:0]  slot;
      logic [COORD_W-1:0] match_x;
      logic [COORD_W-1:0] match_y;
      logic [FILL_W-1:0]  fill;
   } rsp_type;

   typedef struct packed {
      logic               near;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } dist_type;

endpackage

// ----- rtl/core/ptrm_point_mem.sv -----
// Point store of the point table radius match unit: one write port, one read port.
// The read data is registered. Depends on ptrm_pkg.
module ptrm_point_mem #(
   parameter int DEPTH = ptrm_pkg::CAPACITY_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(DEPTH)-1:0]               wr_addr,
   input  logic [2*ptrm_pkg::COORD_W-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]               rd_addr,
   output logic [2*ptrm_pkg::COORD_W-1:0]         rd_data
);
   import ptrm_pkg::*;

   logic [SQ_W-1:0] mem_ff [DEPTH];
   logic [SQ_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ptrm_dist_unit.sv -----
// Shared distance unit: squares the coordinate differences of one stored entry per cycle,
// registers them, then compares their sum against the limit. Depends on ptrm_pkg.
module ptrm_dist_unit (
   input  logic                               clock,
   input  logic [2*ptrm_pkg::COORD_W-1:0]     entry,
   input  logic [ptrm_pkg::COORD_W-1:0]       px,
   input  logic [ptrm_pkg::COORD_W-1:0]       py,
   input  logic [ptrm_pkg::RAD_W-1:0]         limit,
   output ptrm_pkg::dist_type                 result
);
   import ptrm_pkg::*;

   logic [COORD_W-1:0] ex;
   logic [COORD_W-1:0] ey;
   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;
   logic [SQ_W-1:0]    sqx_ff;
   logic [SQ_W-1:0]    sqy_ff;
   logic [COORD_W-1:0] ex_ff;
   logic [COORD_W-1:0] ey_ff;
   logic [SQ_W:0]      sum;

   assign ex = entry[COORD_W-1:0];
   assign ey = entry[SQ_W-1:COORD_W];
   assign dx = (ex > px) ? (ex - px) : (px - ex);
   assign dy = (ey > py) ? (ey - py) : (py - ey);

   always_ff @(posedge clock) begin
      sqx_ff <= SQ_W'(dx) * SQ_W'(dx);
      sqy_ff <= SQ_W'(dy) * SQ_W'(dy);
      ex_ff  <= ex;
      ey_ff  <= ey;
   end

   assign sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_comb begin
      result.near = sum < {{(SQ_W + 1 - RAD_W){1'b0}}, limit};
      result.x    = ex_ff;
      result.y    = ey_ff;
   end

endmodule

// ----- rtl/core/point_table_radius_match_unit.sv -----
// Top level of the point table radius match unit: sequencer, entry count and result register.
// Instantiates ptrm_point_mem and ptrm_dist_unit; depends on ptrm_pkg.
//
// Add, clear and unused kinds, and requests on an empty table, do not scan; busy stays low and the result strobe
// follows in the next cycle. Delete, find and find-or-add scan the table one entry per
// cycle through the shared distance unit and stop at the first hit; a delete that hits
// before the last entry then shifts each later entry down one slot through the single
// write port. The result is shown for exactly one cycle on rsp_strobe; the receiver
// cannot stall it, so it must take every transfer as it comes. The table is empty after
// reset, with no clearing pass.
module point_table_radius_match_unit #(
   parameter int CAPACITY = ptrm_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptrm_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ptrm_pkg::rsp_type rsp_data
);
   import ptrm_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_SHIFT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [COORD_W-1:0] px_ff, px_in;
   logic [COORD_W-1:0] py_ff, py_in;
   logic [RAD_W-1:0]   lim_ff, lim_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  issue_ff, issue_in;
   logic               issue_on_ff, issue_on_in;
   logic               p1_valid_ff, p1_valid_in;
   logic [ADDR_W-1:0]  p1_idx_ff, p1_idx_in;
   logic               p2_valid_ff, p2_valid_in;
   logic [ADDR_W-1:0]  p2_idx_ff, p2_idx_in;
   logic [ADDR_W-1:0]  shift_rd_ff, shift_rd_in;
   logic               shift_on_ff, shift_on_in;
   logic               s_valid_ff, s_valid_in;
   logic [ADDR_W-1:0]  s_waddr_ff, s_waddr_in;
   rsp_type            hold_ff, hold_in;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic               accept;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [SQ_W-1:0]    mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [SQ_W-1:0]    mem_rdata;
   dist_type           dist_res;
   logic [CNT_W-1:0]   last_idx;
   logic               full;
   logic [COORD_W-1:0] cur_x;
   logic [COORD_W-1:0] cur_y;
   logic [ADDR_W+SLOT_W-1:0] slot_wide;
   logic [CNT_W+FILL_W-1:0]  fill_wide;
   logic               do_append;
   logic               finish;
   logic [SLOT_W-1:0]  hit_slot;
   logic [ADDR_W+SLOT_W-1:0] hit_slot_wide;

   assign accept   = start && !busy;
   assign busy     = state_ff != ST_IDLE;
   assign last_idx = count_ff - 1'b1;
   assign full     = count_ff == CNT_W'(CAPACITY);
   assign cur_x    = (state_ff == ST_IDLE) ? req_data.x_coord : px_ff;
   assign cur_y    = (state_ff == ST_IDLE) ? req_data.y_coord : py_ff;
   assign slot_wide     = {{SLOT_W{1'b0}}, count_ff[ADDR_W-1:0]};
   assign hit_slot_wide = {{SLOT_W{1'b0}}, p2_idx_ff};
   assign hit_slot      = hit_slot_wide[SLOT_W-1:0];
   assign fill_wide     = {{FILL_W{1'b0}}, count_in};
   assign mem_raddr     = (state_ff == ST_SHIFT) ? shift_rd_ff : issue_ff;

   ptrm_point_mem #(
      .DEPTH(CAPACITY)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   ptrm_dist_unit u_dist (
      .clock (clock),
      .entry (mem_rdata),
      .px    (px_ff),
      .py    (py_ff),
      .limit (lim_ff),
      .result(dist_res)
   );

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      lim_in      = lim_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      issue_on_in = issue_on_ff;
      p1_valid_in = 1'b0;
      p1_idx_in   = p1_idx_ff;
      p2_valid_in = 1'b0;
      p2_idx_in   = p2_idx_ff;
      shift_rd_in = shift_rd_ff;
      shift_on_in = shift_on_ff;
      s_valid_in  = 1'b0;
      s_waddr_in  = s_waddr_ff;
      hold_in     = hold_ff;
      rsp_in      = '0;
      strobe_in   = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      do_append   = 1'b0;
      finish      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_data.kind;
               px_in   = req_data.x_coord;
               py_in   = req_data.y_coord;
               lim_in  = req_data.radius_sq;
               unique case (req_data.kind)
                  KIND_ADD: begin
                     do_append = 1'b1;
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     finish   = 1'b1;
                  end
                  KIND_DELETE, KIND_FIND, KIND_FIND_ADD: begin
                     if (count_ff == '0) begin
                        if (req_data.kind == KIND_FIND_ADD) begin
                           do_append = 1'b1;
                        end else begin
                           finish = 1'b1;
                        end
                     end else begin
                        state_in    = ST_SCAN;
                        issue_in    = '0;
                        issue_on_in = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            p1_valid_in = issue_on_ff;
            p1_idx_in   = issue_ff;
            p2_valid_in = p1_valid_ff;
            p2_idx_in   = p1_idx_ff;
            if (issue_on_ff) begin
               if (CNT_W'(issue_ff) == last_idx) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_in = issue_ff + 1'b1;
               end
            end
            if (p2_valid_ff && dist_res.near) begin
               hold_in         = '0;
               hold_in.found   = 1'b1;
               hold_in.slot    = hit_slot;
               hold_in.match_x = dist_res.x;
               hold_in.match_y = dist_res.y;
               p1_valid_in     = 1'b0;
               p2_valid_in     = 1'b0;
               issue_on_in     = 1'b0;
               if (kind_ff == KIND_DELETE && CNT_W'(p2_idx_ff) != last_idx) begin
                  state_in    = ST_SHIFT;
                  shift_rd_in = p2_idx_ff + 1'b1;
                  shift_on_in = 1'b1;
               end else begin
                  if (kind_ff == KIND_DELETE) begin
                     count_in = last_idx;
                  end
                  rsp_in   = hold_in;
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (p2_valid_ff && CNT_W'(p2_idx_ff) == last_idx) begin
               state_in = ST_IDLE;
               if (kind_ff == KIND_FIND_ADD) begin
                  do_append = 1'b1;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            s_valid_in = shift_on_ff;
            s_waddr_in = shift_rd_ff - 1'b1;
            if (shift_on_ff) begin
               if (CNT_W'(shift_rd_ff) == last_idx) begin
                  shift_on_in = 1'b0;
               end else begin
                  shift_rd_in = shift_rd_ff + 1'b1;
               end
            end
            if (s_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = s_waddr_ff;
               mem_wdata = mem_rdata;
               if (CNT_W'(s_waddr_ff) + 1'b1 == last_idx) begin
                  count_in = last_idx;
                  rsp_in   = hold_ff;
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_append) begin
         finish = 1'b1;
         if (full) begin
            rsp_in.overflow = 1'b1;
         end else begin
            mem_we         = 1'b1;
            mem_waddr      = count_ff[ADDR_W-1:0];
            mem_wdata      = {cur_y, cur_x};
            rsp_in.added   = 1'b1;
            rsp_in.slot    = slot_wide[SLOT_W-1:0];
            rsp_in.match_x = cur_x;
            rsp_in.match_y = cur_y;
            count_in       = count_ff + 1'b1;
         end
      end

      if (finish) begin
         strobe_in   = 1'b1;
         rsp_in.fill = fill_wide[FILL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         issue_on_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         shift_on_ff <= 1'b0;
         s_valid_ff  <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         issue_on_ff <= issue_on_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         shift_on_ff <= shift_on_in;
         s_valid_ff  <= s_valid_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      lim_ff      <= lim_in;
      issue_ff    <= issue_in;
      p1_idx_ff   <= p1_idx_in;
      p2_idx_ff   <= p2_idx_in;
      shift_rd_ff <= shift_rd_in;
      s_waddr_ff  <= s_waddr_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_SHIFT) |-> count_ff != '0)
      else $error("scan or shift on an empty table");

   a_add_quick: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.kind == KIND_ADD || req_data.kind == KIND_CLEAR)) |=>
      (rsp_strobe && !busy))
      else $error("add or clear did not answer in the next cycle");

   a_found_not_added: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.found && (rsp_data.added || rsp_data.overflow)))
      else $error("result reports a match and an append together");

endmodule
